### design/fwmd_pkg.sv
`default_nettype none

package fwmd_pkg;

  // Queue geometry.
  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Field widths of the stream channels.
  localparam int DATA_W = 32;
  localparam int LEN_W  = 5;
  localparam int FUNC_W = 2;
  localparam int ST_W   = 2;

  // Result tdata layout, lowest bit first: data, length, maximum, removed.
  localparam int OUT_DATA_LSB = 0;
  localparam int OUT_LEN_LSB  = OUT_DATA_LSB + DATA_W;
  localparam int OUT_MAX_LSB  = OUT_LEN_LSB + LEN_W;
  localparam int OUT_REM_LSB  = OUT_MAX_LSB + DATA_W;
  localparam int OUT_USED_W   = OUT_REM_LSB + LEN_W;
  localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_USED_W;

  // Operation codes carried on in_tuser.
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH  = 2'd0,
    FN_POP   = 2'd1,
    FN_DRAIN = 2'd2,
    FN_QUERY = 2'd3
  } fwmd_func_t;

  // Status codes carried on out_tuser.
  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_NOZERO = 2'd3
  } fwmd_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the accepted request and arm the scan
    logic single;    // load the one-result answer into the output register
    logic rd_head;   // read the store at the head
    logic scan;      // walk the held entries
    logic take;      // emit the head element and remove it
  } fwmd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    fwmd_func_t func;
    logic       empty;
    logic       out_free;
    logic       scan_done;
    logic       found;
    logic       take_last;
  } fwmd_sts_t;

  // Ring position after p.
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    if (p == IDX_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/fwmd_ram.sv
`default_nettype none

module fwmd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             wr_en,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                 wr_data,
  input  wire logic                             rd_en,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### design/fwmd_ctrl.sv
`default_nettype none

module fwmd_ctrl
  import fwmd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire fwmd_sts_t sts,
  output fwmd_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FIN,
    S_EM_RD,
    S_EM_WAIT
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands for the current state.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.func == FN_PUSH || sts.empty) begin
          if (sts.out_free) begin
            cmd.single = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else if (sts.func == FN_POP) begin
          cmd.rd_head = 1'b1;
          state_nxt   = S_EM_WAIT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          if (sts.func == FN_DRAIN && sts.found) begin
            state_nxt = S_EM_RD;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.single = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_EM_RD: begin
        cmd.rd_head = 1'b1;
        state_nxt   = S_EM_WAIT;
      end
      S_EM_WAIT: begin
        if (sts.out_free) begin
          cmd.take  = 1'b1;
          state_nxt = sts.take_last ? S_IDLE : S_EM_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### design/fwmd_dp.sv
`default_nettype none

module fwmd_dp
  import fwmd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [DATA_W-1:0]      in_tdata,
  input  wire logic [FUNC_W-1:0]      in_tuser,
  input  wire fwmd_cmd_t              cmd,
  output fwmd_sts_t                   sts,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic [ST_W-1:0]             out_tuser,
  output logic                        out_tlast
);

  // Queue pointers and fill count.
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Current request.
  fwmd_func_t        func_r, func_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;

  // Scan state.
  logic [IDX_W-1:0]         ptr_r, ptr_nxt;
  logic [CNT_W-1:0]         iss_r, iss_nxt;
  logic [CNT_W-1:0]         chk_r, chk_nxt;
  logic                     rd_pend_r, rd_pend_nxt;
  logic                     found_r, found_nxt;
  logic [CNT_W-1:0]         upto_r, upto_nxt;
  logic [CNT_W-1:0]         removed_r, removed_nxt;
  logic signed [DATA_W-1:0] max_r, max_nxt;

  // Output register.
  logic                     ov_r, ov_nxt;
  fwmd_status_t             ost_r, ost_nxt;
  logic [DATA_W-1:0]        odata_r, odata_nxt;
  logic [LEN_W-1:0]         olen_r, olen_nxt;
  logic [DATA_W-1:0]        omax_r, omax_nxt;
  logic [LEN_W-1:0]         orem_r, orem_nxt;
  logic                     olast_r, olast_nxt;

  // Store ports.
  logic                     wr_en;
  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;
  logic [DATA_W-1:0]        rd_data;

  logic                     full;
  logic                     empty;
  logic                     out_free;
  logic                     scan_issue;
  logic                     scan_proc;
  logic                     take_last;
  logic [CNT_W-1:0]         removed_inc;

  assign full        = (cnt_r == CNT_W'(DEPTH));
  assign empty       = (cnt_r == '0);
  assign out_free    = !ov_r || out_tready;
  assign scan_issue  = cmd.scan && (iss_r < cnt_r) && !found_r;
  assign scan_proc   = cmd.scan && rd_pend_r && !found_r;
  assign removed_inc = removed_r + 1'b1;
  assign take_last   = (removed_inc == upto_r);

  assign wr_en   = cmd.single && (func_r == FN_PUSH) && !full;
  assign rd_en   = cmd.rd_head || scan_issue;
  assign rd_addr = cmd.rd_head ? head_r : ptr_r;

  fwmd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (value_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Next-state logic of the datapath.
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    cnt_nxt     = cnt_r;
    func_nxt    = func_r;
    value_nxt   = value_r;
    ptr_nxt     = ptr_r;
    iss_nxt     = iss_r;
    chk_nxt     = chk_r;
    rd_pend_nxt = scan_issue;
    found_nxt   = found_r;
    upto_nxt    = upto_r;
    removed_nxt = removed_r;
    max_nxt     = max_r;
    ov_nxt      = ov_r;
    ost_nxt     = ost_r;
    odata_nxt   = odata_r;
    olen_nxt    = olen_r;
    omax_nxt    = omax_r;
    orem_nxt    = orem_r;
    olast_nxt   = olast_r;

    // The result is taken downstream.
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    // Latch the request and arm the scan at the head.
    if (cmd.capture) begin
      func_nxt    = fwmd_func_t'(in_tuser);
      value_nxt   = in_tdata;
      ptr_nxt     = head_r;
      iss_nxt     = '0;
      chk_nxt     = '0;
      rd_pend_nxt = 1'b0;
      found_nxt   = 1'b0;
      upto_nxt    = CNT_W'(1);
      removed_nxt = '0;
    end

    // Issue the next scan read.
    if (scan_issue) begin
      ptr_nxt = next_idx(ptr_r);
      iss_nxt = iss_r + 1'b1;
    end

    // Check the entry read in the previous cycle.
    if (scan_proc) begin
      chk_nxt = chk_r + 1'b1;
      if (chk_r == '0 || $signed(rd_data) > max_r) begin
        max_nxt = $signed(rd_data);
      end
      if (func_r == FN_DRAIN && rd_data == '0) begin
        found_nxt = 1'b1;
        upto_nxt  = chk_r + 1'b1;
      end
    end

    // Answer that needs a single result.
    if (cmd.single) begin
      ov_nxt    = 1'b1;
      odata_nxt = '0;
      omax_nxt  = '0;
      orem_nxt  = '0;
      olast_nxt = 1'b1;
      if (func_r == FN_PUSH) begin
        if (full) begin
          ost_nxt  = ST_FULL;
          olen_nxt = LEN_W'(cnt_r);
        end else begin
          ost_nxt  = ST_OK;
          olen_nxt = LEN_W'(cnt_r + 1'b1);
          cnt_nxt  = cnt_r + 1'b1;
          tail_nxt = next_idx(tail_r);
        end
      end else if (empty) begin
        ost_nxt  = ST_EMPTY;
        olen_nxt = '0;
      end else if (func_r == FN_QUERY) begin
        ost_nxt  = ST_OK;
        olen_nxt = LEN_W'(cnt_r);
        omax_nxt = max_r;
      end else begin
        ost_nxt  = ST_NOZERO;
        olen_nxt = LEN_W'(cnt_r);
      end
    end

    // Emit the head element and remove it.
    if (cmd.take) begin
      ov_nxt      = 1'b1;
      ost_nxt     = ST_OK;
      odata_nxt   = rd_data;
      olen_nxt    = LEN_W'(cnt_r - 1'b1);
      omax_nxt    = '0;
      orem_nxt    = (func_r == FN_DRAIN) ? LEN_W'(removed_inc) : '0;
      olast_nxt   = take_last;
      head_nxt    = next_idx(head_r);
      cnt_nxt     = cnt_r - 1'b1;
      removed_nxt = removed_inc;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // Payload and scan registers.
  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    value_r   <= value_nxt;
    ptr_r     <= ptr_nxt;
    iss_r     <= iss_nxt;
    chk_r     <= chk_nxt;
    rd_pend_r <= rd_pend_nxt;
    found_r   <= found_nxt;
    upto_r    <= upto_nxt;
    removed_r <= removed_nxt;
    max_r     <= max_nxt;
    ost_r     <= ost_nxt;
    odata_r   <= odata_nxt;
    olen_r    <= olen_nxt;
    omax_r    <= omax_nxt;
    orem_r    <= orem_nxt;
    olast_r   <= olast_nxt;
  end

  // Status toward the controller.
  always_comb begin
    sts.func      = func_r;
    sts.empty     = empty;
    sts.out_free  = out_free;
    sts.scan_done = found_r || (chk_r == cnt_r);
    sts.found     = found_r;
    sts.take_last = take_last;
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = ost_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, orem_r, omax_r, olen_r, odata_r};

endmodule

`default_nettype wire

### design/fifo_with_max_and_drain_to_zero_top.sv
`default_nettype none

// Bounded FIFO of signed 32-bit words with pop, drain-through-first-zero and
// max query. One request is handled at a time; a new request is accepted
// while the last result still waits in the output register. Query and drain
// use the single read port of the ring store to scan the held entries, and
// a drain that finds a zero then reads and removes each element up to it,
// one after another. Results stall without loss while out_tready is low.
module fifo_with_max_and_drain_to_zero_top
  import fwmd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [DATA_W-1:0]      in_tdata,   // value[31:0]
  input  wire logic [FUNC_W-1:0]      in_tuser,   // func[1:0]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // data, length, maximum, removed, zero pad
  output logic [ST_W-1:0]             out_tuser,  // status[1:0]
  output logic                        out_tlast
);

  fwmd_cmd_t cmd;
  fwmd_sts_t sts;

  fwmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fwmd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // A full report always carries a full length.
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FULL |->
      out_tdata[OUT_LEN_LSB +: LEN_W] == LEN_W'(DEPTH))
    else $error("full status with length below depth");

  // An empty report always carries length zero.
  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |-> out_tdata[OUT_LEN_LSB +: LEN_W] == '0)
    else $error("empty status with nonzero length");

  // Elements are never removed from an empty queue.
  a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take || cmd.rd_head |-> !sts.empty)
    else $error("head access on an empty queue");

  // A new result is loaded only when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take || cmd.single) |-> sts.out_free)
    else $error("result loaded over a pending result");

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps

module tb;
  import fwmd_pkg::*;

  localparam int RANDOM_REQUESTS = 388;
  localparam int IDLE_LIMIT      = 2000;
  localparam int SETTLE_CYCLES   = 80;

  // One expected result, in the field order of the result channel.
  typedef struct packed {
    fwmd_status_t status;
    logic [31:0]  data;
    logic [4:0]   length;
    logic [31:0]  maximum;
    logic [4:0]   removed;
    logic         last;
  } queue_result_t;

  // Tracks the queue contents and checks every result against them.
  class queue_scoreboard;
    queue_result_t expected_q[$];
    logic [31:0]   ring[DEPTH];
    int            head;
    int            tail;
    int            fill;
    int            errors;
    int            requests;
    int            results;
    int            full_hits;
    int            empty_hits;
    int            nozero_hits;
    int            longest_drain;

    function new();
      head = 0;
      tail = 0;
      fill = 0;
      errors = 0;
      requests = 0;
      results = 0;
      full_hits = 0;
      empty_hits = 0;
      nozero_hits = 0;
      longest_drain = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      $display("tb: mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void add_result(fwmd_status_t st, logic [31:0] dat, int len,
                             logic [31:0] mx, int rem, logic lst);
      queue_result_t r;
      r.status  = st;
      r.data    = dat;
      r.length  = 5'(len);
      r.maximum = mx;
      r.removed = 5'(rem);
      r.last    = lst;
      expected_q.push_back(r);
    endfunction

    function logic [31:0] take_head();
      logic [31:0] v;
      v = ring[head];
      head = (head + 1) % DEPTH;
      fill--;
      return v;
    endfunction

    // Apply one accepted request to the queue and queue up its results.
    function void note_request(fwmd_func_t fn, logic [31:0] val);
      int          upto;
      int          p;
      logic [31:0] best;
      requests++;
      case (fn)
        FN_PUSH: begin
          if (fill >= DEPTH) begin
            full_hits++;
            add_result(ST_FULL, '0, fill, '0, 0, 1'b1);
          end else begin
            ring[tail] = val;
            tail = (tail + 1) % DEPTH;
            fill++;
            add_result(ST_OK, '0, fill, '0, 0, 1'b1);
          end
        end
        FN_POP: begin
          if (fill == 0) begin
            empty_hits++;
            add_result(ST_EMPTY, '0, 0, '0, 0, 1'b1);
          end else begin
            best = take_head();
            add_result(ST_OK, best, fill, '0, 0, 1'b1);
          end
        end
        FN_DRAIN: begin
          if (fill == 0) begin
            empty_hits++;
            add_result(ST_EMPTY, '0, 0, '0, 0, 1'b1);
          end else begin
            // Find the first zero, counting from the head.
            upto = 0;
            p = head;
            for (int i = 0; i < fill; i++) begin
              if (upto == 0 && ring[p] == '0) begin
                upto = i + 1;
              end
              p = (p + 1) % DEPTH;
            end
            if (upto == 0) begin
              nozero_hits++;
              add_result(ST_NOZERO, '0, fill, '0, 0, 1'b1);
            end else begin
              if (upto > longest_drain) begin
                longest_drain = upto;
              end
              for (int i = 0; i < upto; i++) begin
                best = take_head();
                add_result(ST_OK, best, fill, '0, i + 1, 1'(i + 1 == upto));
              end
            end
          end
        end
        default: begin
          if (fill == 0) begin
            empty_hits++;
            add_result(ST_EMPTY, '0, 0, '0, 0, 1'b1);
          end else begin
            p = head;
            best = ring[p];
            for (int i = 0; i < fill; i++) begin
              if ($signed(ring[p]) > $signed(best)) begin
                best = ring[p];
              end
              p = (p + 1) % DEPTH;
            end
            add_result(ST_OK, '0, fill, best, 0, 1'b1);
          end
        end
      endcase
    endfunction

    // Compare one result from the block with the oldest expectation.
    task check_result(fwmd_status_t st, logic [31:0] dat, logic [4:0] len,
                      logic [31:0] mx, logic [4:0] rem, logic lst);
      queue_result_t e;
      results++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result status %0d data %0h", st, dat));
      end else begin
        e = expected_q.pop_front();
        if (st !== e.status) begin
          report($sformatf("status %0d, expected %0d", st, e.status));
        end
        if (dat !== e.data) begin
          report($sformatf("data %0h, expected %0h", dat, e.data));
        end
        if (len !== e.length) begin
          report($sformatf("length %0d, expected %0d", len, e.length));
        end
        if (mx !== e.maximum) begin
          report($sformatf("maximum %0h, expected %0h", mx, e.maximum));
        end
        if (rem !== e.removed) begin
          report($sformatf("removed %0d, expected %0d", rem, e.removed));
        end
        if (lst !== e.last) begin
          report($sformatf("last %0b, expected %0b", lst, e.last));
        end
      end
    endtask
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [DATA_W-1:0]      in_tdata   = '0;   // value[31:0]
  logic [FUNC_W-1:0]      in_tuser   = FN_PUSH;   // func[1:0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // data, length, maximum, removed, zero pad
  logic [ST_W-1:0]        out_tuser;  // status[1:0]
  logic                   out_tlast;

  queue_scoreboard sb = new();

  fifo_with_max_and_drain_to_zero_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Gap length: mostly none or short, now and then long.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Values lean toward zero, the extremes and small numbers of both signs.
  function logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) begin
      return '0;
    end else if (r < 32) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'hffff_ffff;
        default: return 32'h0000_0001;
      endcase
    end else if (r < 60) begin
      return 32'($signed($urandom_range(0, 40)) - 20);
    end
    return $urandom();
  endfunction

  // Offer one request and hold it until the block takes it.
  task send_request(fwmd_func_t fn, logic [31:0] val);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= val;
    do begin
      @(posedge clk);
    end while (in_tready !== 1'b1);
    sb.note_request(fn, val);
  endtask

  task idle_sender(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Hold off new requests until every expected result has arrived.
  task wait_for_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Receiver: a stretch of steady readiness, then a stretch of random stalls.
  initial begin : ready_gen
    int left;
    int span;
    left = 0;
    span = 0;
    forever begin
      @(negedge clk);
      span = (span + 1) % 400;
      if (span < 120) begin
        out_tready <= 1'b1;
      end else if (left > 0) begin
        out_tready <= 1'b0;
        left--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          left = pick_gap();
        end
      end
    end
  end

  // Check every result the block hands over.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(fwmd_status_t'(out_tuser),
                      out_tdata[OUT_DATA_LSB +: DATA_W],
                      out_tdata[OUT_LEN_LSB +: LEN_W],
                      out_tdata[OUT_MAX_LSB +: DATA_W],
                      out_tdata[OUT_REM_LSB +: LEN_W],
                      out_tlast);
    end
  end

  // Stop the run if neither channel moves for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("tb: no request or result moved for %0d cycles", IDLE_LIMIT);
    $display("tb: errors");
    $finish;
  end

  initial begin : main
    int          sent;
    int          burst;
    int          mode;
    int          r;
    fwmd_func_t  fn;
    sent = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty cases, extremes, no-zero drain, drains of several and one.
    send_request(FN_QUERY, '0);
    send_request(FN_POP, '0);
    send_request(FN_DRAIN, 32'hffff_ffff);
    send_request(FN_PUSH, 32'h8000_0000);
    send_request(FN_QUERY, '0);
    send_request(FN_PUSH, 32'h7fff_ffff);
    send_request(FN_PUSH, 32'hffff_ffff);
    send_request(FN_QUERY, '0);
    send_request(FN_DRAIN, '0);
    send_request(FN_PUSH, '0);
    send_request(FN_PUSH, 32'd7);
    send_request(FN_DRAIN, '0);
    send_request(FN_QUERY, '0);
    send_request(FN_POP, '0);
    send_request(FN_POP, '0);
    send_request(FN_PUSH, '0);
    send_request(FN_DRAIN, '0);
    send_request(FN_PUSH, 32'hffff_fffb);
    send_request(FN_PUSH, 32'hffff_fffd);
    send_request(FN_QUERY, 32'h5555_aaaa);
    send_request(FN_POP, '0);
    send_request(FN_POP, '0);
    wait_for_results();

    // Random bursts: runs that fill the queue to overflow, runs that empty it,
    // and mixed traffic.
    while (sent < RANDOM_REQUESTS) begin
      mode = $urandom_range(0, 2);
      burst = (mode == 0) ? $urandom_range(17, 22) : $urandom_range(8, 30);
      for (int i = 0; i < burst && sent < RANDOM_REQUESTS; i++) begin
        r = $urandom_range(0, 99);
        if (mode == 0) begin
          fn = (r < 85) ? FN_PUSH : fwmd_func_t'($urandom_range(1, 3));
        end else if (mode == 1) begin
          if (r < 35) begin
            fn = FN_POP;
          end else if (r < 70) begin
            fn = FN_DRAIN;
          end else if (r < 85) begin
            fn = FN_QUERY;
          end else begin
            fn = FN_PUSH;
          end
        end else begin
          fn = fwmd_func_t'($urandom_range(0, 3));
        end
        send_request(fn, (fn == FN_PUSH) ? pick_value() : 32'($urandom()));
        sent++;
        idle_sender(pick_gap());
      end
      if ($urandom_range(0, 4) == 0) begin
        wait_for_results();
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("tb: %0d requests, %0d results checked, drains up to %0d elements",
             sb.requests, sb.results, sb.longest_drain);
    $display("tb: full pushes %0d, empty requests %0d, drains without a zero %0d",
             sb.full_hits, sb.empty_hits, sb.nozero_hits);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
